FILE: rtl/core/gwwl_pkg.sv
// ----------------------------------------------------------------------------
// gwwl_pkg
// Shared types and constants of the greedy word-wrap layout block.
// ----------------------------------------------------------------------------
package gwwl_pkg;

  localparam int COL_W  = 7;
  localparam int ROW_W  = 6;
  localparam int CHAR_W = 8;
  localparam int LEN_W  = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  localparam int WORD_MAX_DEF = 62;
  localparam int ROW_ADVANCE  = 2;

  localparam logic [CHAR_W-1:0] SPACE_CODE = 8'd32;
  localparam logic [COL_W-1:0]  COL_LIMIT  = 7'd127;
  localparam logic [ROW_W-1:0]  ROW_LIMIT  = 6'd63;

  localparam logic [COL_W-1:0] LINE_END_RST   = 7'd46;
  localparam logic [COL_W-1:0] LINE_START_RST = 7'd14;
  localparam logic [ROW_W-1:0] FIRST_ROW_RST  = 6'd14;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_END   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_START = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_ROW  = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_STORE,
    S_TAIL,
    S_FL_CHECK,
    S_FL_CELL,
    S_FL_SPACE,
    S_END
  } ctrl_state_t;

  // What a word flush was started for, and so where it returns to.
  typedef enum logic [1:0] {
    FK_SPACE,
    FK_FULL,
    FK_FINAL
  } flush_kind_t;

  typedef struct packed {
    logic accept;
    logic store;
    logic wrap_check;
    logic cell_emit;
    logic space_emit;
    logic end_emit;
    logic clear_len;
    logic lor;
  } dp_cmd_t;

  typedef struct packed {
    logic is_space;
    logic item_last;
    logic word_full;
    logic word_empty;
    logic cell_last;
    logic space_ok;
    logic space_after_ok;
    logic out_free;
  } dp_stat_t;

endpackage

FILE: rtl/core/gwwl_ctrl.sv
// ----------------------------------------------------------------------------
// gwwl_ctrl
// Sequencer of the word-wrap block: steps through buffering, flushing and
// the end marker of each request.
// ----------------------------------------------------------------------------
module gwwl_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  gwwl_pkg::dp_stat_t stat,
  output gwwl_pkg::dp_cmd_t  cmd
);
  import gwwl_pkg::*;

  ctrl_state_t state, state_next;
  flush_kind_t kind, kind_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      kind  <= FK_SPACE;
    end else begin
      state <= state_next;
      kind  <= kind_next;
    end
  end

  always_comb begin
    logic with_space;
    state_next = state;
    kind_next  = kind;
    cmd        = '0;
    in_stall   = 1'b1;
    with_space = (kind == FK_SPACE);
    case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (stat.is_space) begin
          kind_next  = FK_SPACE;
          state_next = S_FL_CHECK;
        end else if (stat.word_full) begin
          kind_next  = FK_FULL;
          state_next = S_FL_CHECK;
        end else begin
          state_next = S_STORE;
        end
      end
      S_STORE: begin
        cmd.store  = 1'b1;
        state_next = S_TAIL;
      end
      S_TAIL: begin
        if (!stat.item_last) begin
          state_next = S_IDLE;
        end else if (stat.is_space) begin
          state_next = S_END;
        end else begin
          kind_next  = FK_FINAL;
          state_next = S_FL_CHECK;
        end
      end
      S_FL_CHECK: begin
        cmd.wrap_check = 1'b1;
        state_next     = stat.word_empty ? S_FL_SPACE : S_FL_CELL;
      end
      S_FL_CELL: begin
        if (stat.out_free) begin
          cmd.cell_emit = 1'b1;
          cmd.lor       = stat.cell_last && !stat.item_last &&
                          !(with_space && stat.space_after_ok);
          if (stat.cell_last) begin
            state_next = S_FL_SPACE;
          end
        end
      end
      S_FL_SPACE: begin
        if (!(with_space && stat.space_ok) || stat.out_free) begin
          cmd.space_emit = with_space && stat.space_ok;
          cmd.lor        = !stat.item_last;
          cmd.clear_len  = 1'b1;
          case (kind)
            FK_SPACE: state_next = S_TAIL;
            FK_FULL:  state_next = S_STORE;
            FK_FINAL: state_next = S_END;
            default:  state_next = S_IDLE;
          endcase
        end
      end
      S_END: begin
        if (stat.out_free) begin
          cmd.end_emit = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

FILE: rtl/core/gwwl_dpath.sv
// ----------------------------------------------------------------------------
// gwwl_dpath
// Datapath of the word-wrap block: configuration, word buffer, cursor and
// the output register.
// ----------------------------------------------------------------------------
module gwwl_dpath #(
  parameter int WORD_MAX = gwwl_pkg::WORD_MAX_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [gwwl_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [gwwl_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic [gwwl_pkg::CHAR_W-1:0]      char_code,
  input  logic                             is_last,
  input  logic                             out_stall,
  output logic                             out_valid,
  output logic [gwwl_pkg::COL_W-1:0]       cell_col,
  output logic [gwwl_pkg::ROW_W-1:0]       cell_row,
  output logic [gwwl_pkg::CHAR_W-1:0]      cell_char,
  output logic                             end_marker,
  output logic                             last_of_run,
  input  gwwl_pkg::dp_cmd_t                cmd,
  output gwwl_pkg::dp_stat_t               stat
);
  import gwwl_pkg::*;

  localparam int IDX_W = $clog2(WORD_MAX);

  logic [COL_W-1:0]  line_end_col;
  logic [COL_W-1:0]  line_start_col;
  logic [ROW_W-1:0]  first_row;
  logic [CHAR_W-1:0] item_char;
  logic              item_last;
  logic              at_start;
  logic [LEN_W-1:0]  word_len;
  logic [COL_W-1:0]  cursor_col;
  logic [ROW_W-1:0]  cursor_row;
  logic [IDX_W-1:0]  rd_idx;
  logic [CHAR_W-1:0] rd_data;
  logic [CHAR_W-1:0] word_mem [WORD_MAX];

  logic [COL_W-1:0]  col_next;
  logic [COL_W:0]    fit_sum;
  logic [COL_W:0]    fit_room;
  logic              do_wrap;
  logic [ROW_W:0]    row_sum;
  logic [ROW_W-1:0]  row_wrapped;
  logic              rd_en;
  logic [IDX_W-1:0]  rd_addr;
  logic              out_load;

  // Saturating column and row steps and the line-fit test.
  assign col_next    = (cursor_col == COL_LIMIT) ? cursor_col : cursor_col + 7'd1;
  assign fit_sum     = {2'b00, word_len} + {1'b0, cursor_col};
  assign fit_room    = {1'b0, line_end_col} + 8'd1;
  assign do_wrap     = fit_sum > fit_room;
  assign row_sum     = {1'b0, cursor_row} + (ROW_W+1)'(ROW_ADVANCE);
  assign row_wrapped = (row_sum > {1'b0, ROW_LIMIT}) ? ROW_LIMIT : row_sum[ROW_W-1:0];

  assign stat.is_space       = (item_char == SPACE_CODE);
  assign stat.item_last      = item_last;
  assign stat.word_full      = (word_len >= LEN_W'(WORD_MAX));
  assign stat.word_empty     = (word_len == '0);
  assign stat.cell_last      = (LEN_W'(rd_idx) == word_len - 6'd1);
  assign stat.space_ok       = (cursor_col < line_end_col);
  assign stat.space_after_ok = (col_next < line_end_col);
  assign stat.out_free       = !out_valid || !out_stall;

  assign rd_en    = cmd.wrap_check || (cmd.cell_emit && !stat.cell_last);
  assign rd_addr  = cmd.wrap_check ? '0 : rd_idx + IDX_W'(1);
  assign out_load = cmd.cell_emit || cmd.space_emit || cmd.end_emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_end_col   <= LINE_END_RST;
      line_start_col <= LINE_START_RST;
      first_row      <= FIRST_ROW_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LINE_END:   line_end_col   <= cfg_data[COL_W-1:0];
        CFG_LINE_START: line_start_col <= cfg_data[COL_W-1:0];
        CFG_FIRST_ROW:  first_row      <= cfg_data[ROW_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      item_char <= char_code;
      item_last <= is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      at_start   <= 1'b1;
      word_len   <= '0;
      cursor_col <= '0;
      cursor_row <= '0;
      rd_idx     <= '0;
    end else begin
      if (cmd.accept && at_start) begin
        at_start   <= 1'b0;
        word_len   <= '0;
        cursor_col <= line_start_col;
        cursor_row <= first_row;
      end
      if (cmd.end_emit) begin
        at_start <= 1'b1;
      end
      if (cmd.store) begin
        word_len <= word_len + 6'd1;
      end
      if (cmd.clear_len) begin
        word_len <= '0;
      end
      if (cmd.wrap_check) begin
        rd_idx <= '0;
        if (do_wrap) begin
          cursor_col <= line_start_col;
          cursor_row <= row_wrapped;
        end
      end
      if (cmd.cell_emit) begin
        rd_idx <= rd_idx + IDX_W'(1);
      end
      if (cmd.cell_emit || cmd.space_emit) begin
        cursor_col <= col_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store) begin
      word_mem[word_len[IDX_W-1:0]] <= item_char;
    end
    if (rd_en) begin
      rd_data <= word_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      cell_row    <= cursor_row;
      end_marker  <= cmd.end_emit;
      last_of_run <= cmd.end_emit ? 1'b1 : cmd.lor;
      if (cmd.end_emit) begin
        cell_col  <= '0;
        cell_char <= '0;
      end else begin
        cell_col  <= cursor_col;
        cell_char <= cmd.space_emit ? SPACE_CODE : rd_data;
      end
    end
  end

endmodule

FILE: rtl/core/greedy_word_wrap_layout.sv
// ----------------------------------------------------------------------------
// greedy_word_wrap_layout
// Greedy word wrap of a character string onto a character-cell display.
// ----------------------------------------------------------------------------
// The block takes a string one character per input request and buffers the
// current word in an internal memory until a space or the last character.
// A finished word that does not fit in the room left on the line moves the
// cursor to line_start_col and ROW_ADVANCE rows down, saturating at row 63;
// then each character goes out as one cell write with its column and row,
// followed by one space write when the word ended on a space and the cursor
// is still left of line_end_col. After the last character an end marker
// carries the final row; last_of_run flags the final result of each input.
// A character that only joins the buffered word is accepted, decoded and
// stored, and produces nothing. A space that flushes a word of n characters
// passes through the accept, the decode of the character, the wrap
// decision, the replay in which the registered read port of the word memory
// streams out one cell per cycle while the output is not stalled, the
// trailing space and a finishing step. A word flushed because the buffer is
// full is followed by a store of the new character. A last character adds
// the end marker, and when it is not a space it is stored and its word
// flushed first. A stall on the output holds the replay in place. The input
// is taken only between requests, but an earlier result may still sit in
// the output register at that time. Configuration writes are taken in any
// cycle and must only occur while the block is idle; a write to an index
// beyond first_row is ignored.
// ----------------------------------------------------------------------------
module greedy_word_wrap_layout #(
  parameter int WORD_MAX = gwwl_pkg::WORD_MAX_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [gwwl_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [gwwl_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [gwwl_pkg::CHAR_W-1:0]      char_code,
  input  logic                             is_last,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [gwwl_pkg::COL_W-1:0]       cell_col,
  output logic [gwwl_pkg::ROW_W-1:0]       cell_row,
  output logic [gwwl_pkg::CHAR_W-1:0]      cell_char,
  output logic                             end_marker,
  output logic                             last_of_run
);
  import gwwl_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // The sequencer decides what happens in each cycle of a request.
  gwwl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // The datapath holds all state that the sequencer acts upon.
  gwwl_dpath #(
    .WORD_MAX (WORD_MAX)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .char_code   (char_code),
    .is_last     (is_last),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .cell_col    (cell_col),
    .cell_row    (cell_row),
    .cell_char   (cell_char),
    .end_marker  (end_marker),
    .last_of_run (last_of_run),
    .cmd         (cmd),
    .stat        (stat)
  );

endmodule

FILE: rtl/core/gwwl_checker.sv
// ----------------------------------------------------------------------------
// gwwl_checker
// Port-level checks of the word-wrap block, bound to its top level.
// ----------------------------------------------------------------------------
module gwwl_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             cfg_we,
  input logic                             in_valid,
  input logic                             in_stall,
  input logic [gwwl_pkg::CHAR_W-1:0]      char_code,
  input logic                             is_last,
  input logic                             out_valid,
  input logic                             out_stall,
  input logic [gwwl_pkg::COL_W-1:0]       cell_col,
  input logic [gwwl_pkg::ROW_W-1:0]       cell_row,
  input logic [gwwl_pkg::CHAR_W-1:0]      cell_char,
  input logic                             end_marker,
  input logic                             last_of_run
);

  // A result held back by the consumer stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid &&
      $stable({cell_col, cell_row, cell_char, end_marker, last_of_run}))
    else $error("output result changed while stalled");

  // The end marker closes its run and writes no character.
  a_end_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && end_marker |-> last_of_run && cell_char == 8'd0 && cell_col == 7'd0)
    else $error("malformed end marker");

  // Each request is worked on alone, so the input is held off right after one.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken in back-to-back cycles");

  // A request that is held off stays offered and unchanged.
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=> in_valid && $stable({char_code, is_last}))
    else $error("input request changed while stalled");

  // Registers are only written while the block is idle and drained.
  a_cfg_idle: assert property (@(posedge clk) disable iff (rst)
    cfg_we |-> !in_stall && !out_valid)
    else $error("configuration written while busy");

endmodule

bind greedy_word_wrap_layout gwwl_checker u_gwwl_checker (.*);
